// ----- src/cdd_pkg.sv -----
// Shared types, constants and calendar tables for the date difference block.
package cdd_pkg;

  // Field widths
  localparam int YEAR_W = 14;
  localparam int MON_W  = 7;
  localparam int DAY_W  = 7;
  localparam int DIFF_W = 23;
  localparam int STAT_W = 2;
  localparam int DNUM_W = 24;  // signed day number
  localparam int MOFF_W = 9;   // month offset, at most 337
  localparam int CORR_W = 13;  // leap correction y/4 - y/100 + y/400
  localparam int PROD_W = 27;  // year times reciprocal of 100

  // Status codes
  localparam logic [STAT_W-1:0] ST_VALID = 2'd0;
  localparam logic [STAT_W-1:0] ST_MONTH = 2'd1;
  localparam logic [STAT_W-1:0] ST_DAY   = 2'd2;

  // Division by 100 via reciprocal: exact for years below 2^14
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [23:0] DAYS_YEAR   = 24'd365;

  // Saturation bounds of the result
  localparam logic signed [24:0] DIFF_HI = 25'sd4194303;
  localparam logic signed [24:0] DIFF_LO = -25'sd4194304;

  typedef struct packed {
    logic [YEAR_W-1:0] first_year;
    logic [MON_W-1:0]  first_month;
    logic [DAY_W-1:0]  first_day;
    logic [YEAR_W-1:0] second_year;
    logic [MON_W-1:0]  second_month;
    logic [DAY_W-1:0]  second_day;
  } date_pair_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] difference_days;
    logic [STAT_W-1:0]        first_status;
    logic [STAT_W-1:0]        second_status;
  } diff_res_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DNUM_W-1:0] day_num;
  } lane_res_t;

  // Longest day of a month, Feb taken as 29
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd29;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (mm*306+5)/10 for the March-based month 0..11
  function automatic logic [MOFF_W-1:0] month_off(input logic [3:0] mm);
    logic [MOFF_W-1:0] off;
    case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- src/cdd_lane.sv -----
// One date lane: validation and day number, three register stages.
module cdd_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cdd_pkg::YEAR_W-1:0] year,
  input  logic [cdd_pkg::MON_W-1:0]  month,
  input  logic [cdd_pkg::DAY_W-1:0]  day,
  output cdd_pkg::lane_res_t         res
);
  import cdd_pkg::*;

  // Stage 1 signals
  logic              m_bad, d_bad, feb29, early;
  logic [3:0]        mm;
  logic [YEAR_W-1:0] yd_c;

  logic              s1_m_bad, s1_d_bad, s1_feb29, s1_neg, s1_yzero, s1_y4;
  logic [YEAR_W-1:0] s1_yd;
  logic [PROD_W-1:0] s1_prod;
  logic [MOFF_W-1:0] s1_moff;
  logic [DAY_W-1:0]  s1_day;

  // Stage 2 signals
  logic [7:0]               q100;
  logic [YEAR_W-1:0]        rem_full;
  logic                     leap;
  logic [STAT_W-1:0]        status_c;
  logic signed [DNUM_W-1:0] y365_c;
  logic [CORR_W-1:0]        corr_c;

  logic [STAT_W-1:0]        s2_status;
  logic signed [DNUM_W-1:0] s2_y365;
  logic [CORR_W-1:0]        s2_corr;
  logic [MOFF_W-1:0]        s2_moff;
  logic [DAY_W-1:0]         s2_day;

  // Stage 1: range checks, month shift, reciprocal product for y/100
  always_comb begin
    m_bad = (month == '0) || (month > MON_W'(12));
    d_bad = (day == '0) || (day > DAY_W'(month_len(month[3:0])));
    feb29 = (month == MON_W'(2)) && (day == DAY_W'(29));
    early = (month <= MON_W'(2));
    mm    = early ? (month[3:0] + 4'd9) : (month[3:0] - 4'd3);
    if (early && (year != '0)) begin
      yd_c = year - YEAR_W'(1);
    end else if (early) begin
      yd_c = '0;
    end else begin
      yd_c = year;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_bad <= m_bad;
      s1_d_bad <= d_bad;
      s1_feb29 <= feb29;
      s1_neg   <= early && (year == '0);
      s1_yzero <= (year == '0);
      s1_y4    <= (year[1:0] == 2'b00);
      s1_yd    <= yd_c;
      s1_prod  <= PROD_W'(yd_c) * PROD_W'(RECIP100);
      s1_moff  <= month_off(mm);
      s1_day   <= day;
    end
  end

  // Stage 2: quotients, leap test on the decremented year, status
  always_comb begin
    q100     = s1_prod[PROD_W-1:RECIP_SHIFT];
    rem_full = s1_yd - YEAR_W'(q100) * YEAR_W'(100);
    // Feb 29 only: y%100==0 <=> (y-1)%100==99, y%400==0 also needs q%4==3
    leap = s1_yzero ||
           (s1_y4 && !((rem_full[6:0] == 7'd99) && (q100[1:0] != 2'b11)));
    if (s1_m_bad) begin
      status_c = ST_MONTH;
    end else if (s1_d_bad || (s1_feb29 && !leap)) begin
      status_c = ST_DAY;
    end else begin
      status_c = ST_VALID;
    end
    if (s1_neg) begin
      y365_c = -DNUM_W'(365);
      corr_c = '0;
    end else begin
      y365_c = signed'(DNUM_W'(s1_yd) * DAYS_YEAR);
      corr_c = CORR_W'(s1_yd >> 2) - CORR_W'(q100) + CORR_W'(q100 >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_status <= status_c;
      s2_y365   <= y365_c;
      s2_corr   <= corr_c;
      s2_moff   <= s1_moff;
      s2_day    <= s1_day;
    end
  end

  // Stage 3: day number sum
  always_ff @(posedge clk) begin
    if (en) begin
      res.status  <= s2_status;
      res.day_num <= s2_y365 + signed'(DNUM_W'(s2_corr))
                   + signed'(DNUM_W'(s2_moff)) + signed'(DNUM_W'(s2_day));
    end
  end

endmodule

// ----- src/cdd_merge.sv -----
// Merge stage: subtract day numbers, saturate, zero on an invalid date.
module cdd_merge (
  input  logic               clk,
  input  logic               en,
  input  cdd_pkg::lane_res_t first,
  input  cdd_pkg::lane_res_t second,
  output cdd_pkg::diff_res_t res
);
  import cdd_pkg::*;

  logic signed [DNUM_W:0]   diff_wide;
  logic signed [DIFF_W-1:0] diff_c;

  always_comb begin
    diff_wide = {first.day_num[DNUM_W-1], first.day_num}
              - {second.day_num[DNUM_W-1], second.day_num};
    if ((first.status != ST_VALID) || (second.status != ST_VALID)) begin
      diff_c = '0;
    end else if (diff_wide > DIFF_HI) begin
      diff_c = DIFF_HI[DIFF_W-1:0];
    end else if (diff_wide < DIFF_LO) begin
      diff_c = DIFF_LO[DIFF_W-1:0];
    end else begin
      diff_c = diff_wide[DIFF_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      res.difference_days <= diff_c;
      res.first_status    <= first.status;
      res.second_status   <= second.status;
    end
  end

endmodule

// ----- src/calendar_date_difference_top.sv -----
// Top level of the date difference block: two date lanes and a merge stage.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------
//   input   | date_valid / date_ready | date (cdd_pkg::date_pair_t)
//   output  | diff_valid / diff_ready | diff (cdd_pkg::diff_res_t)
//
// One beat per cycle sustained while the output is taken; the pipe has three lane
// stages, then the merge register, which is the output register.
// The two dates run in separate lanes; the merge stage joins them.
// Reset (rst, synchronous) clears the stage valid bits only.
// When the output beat is held, the whole pipe holds and date_ready drops;
// an empty output register or a taken beat lets every stage advance.
module calendar_date_difference_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                date_valid,
  output logic                date_ready,
  input  cdd_pkg::date_pair_t date,
  output logic                diff_valid,
  input  logic                diff_ready,
  output cdd_pkg::diff_res_t  diff
);
  import cdd_pkg::*;

  logic      advance;
  logic [3:0] vld;
  lane_res_t first_res, second_res;

  assign advance    = !vld[3] || diff_ready;
  assign date_ready = advance;
  assign diff_valid = vld[3];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[2:0], date_valid};
    end
  end

  cdd_lane u_lane_first (
    .clk   (clk),
    .en    (advance),
    .year  (date.first_year),
    .month (date.first_month),
    .day   (date.first_day),
    .res   (first_res)
  );

  cdd_lane u_lane_second (
    .clk   (clk),
    .en    (advance),
    .year  (date.second_year),
    .month (date.second_month),
    .day   (date.second_day),
    .res   (second_res)
  );

  cdd_merge u_merge (
    .clk    (clk),
    .en     (advance),
    .first  (first_res),
    .second (second_res),
    .res    (diff)
  );

`ifndef ASSERT_OFF
  // An invalid date always yields a zero difference
  a_zero_on_invalid: assert property (@(posedge clk) disable iff (rst)
    diff_valid && ((diff.first_status != ST_VALID) ||
                   (diff.second_status != ST_VALID))
    |-> (diff.difference_days == '0))
    else $error("nonzero difference with an invalid date");

  // A taken input beat enters the first stage
  a_beat_enters: assert property (@(posedge clk) disable iff (rst)
    date_valid && date_ready |=> vld[0])
    else $error("accepted beat lost at stage one");

  // A held output beat freezes the pipe valid bits
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    diff_valid && !diff_ready |=> $stable(vld))
    else $error("pipe moved during output stall");
`endif

endmodule
